// File: hdl/msfr_pkg.sv
// Shared types, constants and helpers of the multi-source frame reassembler.
package msfr_pkg;

    localparam int SOURCES      = 6;
    localparam int RING_DEPTH   = 64;
    localparam int LATE_WINDOW  = 8;
    localparam int SILENT_LIMIT = 80;

    localparam int SLOT_W    = $clog2(RING_DEPTH);
    localparam int SRC_IDX_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int FRAME_W   = 32;
    localparam int CNT_W     = 7;
    localparam int CNT_MAX   = 127;
    localparam int SRC_W     = 3;
    localparam int SLOT_FW   = 6;
    localparam int MASK_FW   = 6;
    localparam int CFG_W     = 6;

    localparam logic [SOURCES-1:0] FULL_MASK = '1;

    // Configuration register indexes
    localparam logic CFG_ABSENT = 1'b0;
    localparam logic CFG_STEP   = 1'b1;

    // Result kinds and placement outcomes
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_PUSH   = 1'b1;

    typedef enum logic [1:0] {
        OC_JOIN = 2'd0,
        OC_OPEN = 2'd1,
        OC_LATE = 2'd2,
        OC_DUP  = 2'd3
    } t_outcome;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_OUT0   = 5'b01000,
        S_OUT1   = 5'b10000
    } t_state;

    typedef logic [SOURCES-1:0][CNT_W-1:0] t_miss;

    // Search request broadcast to every slot cell
    typedef struct packed {
        logic [FRAME_W-1:0] fn;
        logic [SOURCES-1:0] srcbit;
        logic               sync;
        logic [SLOT_W-1:0]  oldest;
        logic [SLOT_W-1:0]  retired;
        logic [SLOT_W-1:0]  span;
        logic               live;
    } t_query;

    // Running search result handed from cell to cell
    typedef struct packed {
        logic               tok;
        logic               found;
        logic [SLOT_W-1:0]  best_d;
        logic [SLOT_W-1:0]  best_idx;
        logic [FRAME_W-1:0] best_frame;
        logic [SOURCES-1:0] best_mask;
        logic [FRAME_W-1:0] ret_frame;
        logic [FRAME_W-1:0] old_frame;
        logic [SOURCES-1:0] old_mask;
    } t_carry;

    // Slot write
    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  addr;
        logic [FRAME_W-1:0] frame;
        logic [SOURCES-1:0] mask;
    } t_wr;

    // One result item
    typedef struct packed {
        logic               kind;
        logic [1:0]         outcome;
        logic [SLOT_FW-1:0] slot;
        logic               gap;
        logic [FRAME_W-1:0] pf;
        logic [MASK_FW-1:0] pp;
        logic [MASK_FW-1:0] sil;
        logic               last;
    } t_res;

    typedef struct packed {
        logic [SOURCES-1:0] sil;
        t_miss              miss;
    } t_sil_upd;

    function automatic logic [SLOT_W-1:0] ring_inc(input logic [SLOT_W-1:0] a);
        logic [SLOT_W-1:0] r;
        r = (a == SLOT_W'(RING_DEPTH - 1)) ? '0 : a + SLOT_W'(1);
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] ring_sub(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] t;
        if (a >= b) t = {1'b0, a} - {1'b0, b};
        else        t = {1'b0, a} + (SLOT_W+1)'(RING_DEPTH) - {1'b0, b};
        return t[SLOT_W-1:0];
    endfunction

    // Silent-source bookkeeping for one pushed frame
    function automatic t_sil_upd silent_update(input logic [SOURCES-1:0] sil,
                                               input t_miss miss,
                                               input logic [SOURCES-1:0] pm);
        t_sil_upd u;
        u.sil  = sil;
        u.miss = miss;
        for (int i = 0; i < SOURCES; i++) begin
            if (sil[i]) begin
                if (int'(miss[i]) < LATE_WINDOW) begin
                    u.miss[i] = '0;
                    u.sil[i]  = 1'b0;
                end
            end else if (!pm[i]) begin
                if (int'(miss[i]) < CNT_MAX) u.miss[i] = miss[i] + CNT_W'(1);
                if (int'(miss[i]) > SILENT_LIMIT) u.sil[i] = 1'b1;
            end
        end
        return u;
    endfunction

endpackage

// File: hdl/msfr_cell.sv
// One ring slot: holds frame number and presence mask, takes part in the search chain.
module msfr_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [msfr_pkg::SLOT_W-1:0]      i_idx,
    input  msfr_pkg::t_query                 i_q,
    input  msfr_pkg::t_wr                    i_wr,
    input  msfr_pkg::t_carry                 i_c,
    output msfr_pkg::t_carry                 o_c
);
    import msfr_pkg::*;

    logic [FRAME_W-1:0] r_frame;
    logic [SOURCES-1:0] r_mask;
    t_carry             r_c;
    t_carry             n_c;
    logic [SLOT_W-1:0]  w_d;
    logic               w_live;
    logic               w_cand;
    logic               w_take;

    // Judge this slot against the request and fold it into the running result
    always_comb begin
        w_d    = ring_sub(i_idx, i_q.oldest);
        w_live = i_q.live && (w_d <= i_q.span);
        w_cand = w_live && (i_q.sync ? (r_frame == i_q.fn) : ((r_mask & i_q.srcbit) == '0));
        w_take = w_cand && (!i_c.found || (i_q.sync ? (w_d > i_c.best_d) : (w_d < i_c.best_d)));
        n_c = i_c;
        if (w_take) begin
            n_c.found      = 1'b1;
            n_c.best_d     = w_d;
            n_c.best_idx   = i_idx;
            n_c.best_frame = r_frame;
            n_c.best_mask  = r_mask;
        end
        if (i_idx == i_q.retired) n_c.ret_frame = r_frame;
        if (i_idx == i_q.oldest) begin
            n_c.old_frame = r_frame;
            n_c.old_mask  = r_mask;
        end
    end

    // Hand the result on to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.tok <= 1'b0;
        end else begin
            r_c <= n_c;
        end
    end

    // Hold slot contents, update on a write to this slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
            r_mask  <= '0;
        end else if (i_wr.en && i_wr.addr == i_idx) begin
            r_frame <= i_wr.frame;
            r_mask  <= i_wr.mask;
        end
    end

    assign o_c = r_c;

endmodule

// File: hdl/multi_source_frame_reassembler.sv
// Top level of the multi-source frame reassembler: control, chain of slot cells, result output.
//
// Input channel (i_s_*): one item per frame arrival, tdata carries source id and
// frame number, tuser the sync flag. Output channel (o_m_*): one to two result
// items per arrival, tuser the kind (placement report or pushed frame), tlast on
// the final result of the arrival. Arrivals from an unknown source give no result.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data; user writes only while idle (not enforced).
//
// Each arrival runs a search token down the chain of RING_DEPTH slot cells, one
// cell per cycle; the slot match, the retired slot's frame and the oldest slot are
// gathered on the way. After the token leaves the chain, the decide state places
// the arrival, and its results are loaded one by one into the output register.
// Only one arrival is processed at a time.
// A result waits in the output register while the receiver stalls; the next
// arrival is still accepted and searched, and its results queue behind it.
// Reset (synchronous, active low) empties the ring, clears all slots, sequence
// and silence tracking, and sets absent mask 0 and frame step 1.
module multi_source_frame_reassembler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [2:0] source_id, [34:3] frame_number, zero fill
    input  logic        i_s_tuser,   // [0] sync_mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // [1:0] outcome, [7:2] slot_index, [8] sequence_gap,
                                     // [40:9] pushed_frame_number, [46:41] pushed_present,
                                     // [52:47] silent_mask, zero fill
    output logic        o_m_tuser,   // [0] kind
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [5:0]  i_cfg_data
);
    import msfr_pkg::*;

    t_state             r_state;
    logic               r_launch;
    logic [SOURCES-1:0] r_absent;
    logic [1:0]         r_step;
    logic [SLOT_W-1:0]  r_newest;
    logic [SLOT_W-1:0]  r_retired;
    logic [FRAME_W-1:0] r_prev [SOURCES];
    logic [SOURCES-1:0] r_prev_v;
    t_miss              r_miss;
    logic [SOURCES-1:0] r_sil;
    logic [SRC_IDX_W-1:0] r_src;
    logic               r_sync;
    logic [FRAME_W-1:0] r_fn;
    logic               r_gap;
    t_res               r_res0;
    t_res               r_res1;
    logic               r_two;
    t_res               r_out;
    logic               r_out_v;

    t_carry             w_c [RING_DEPTH+1];
    t_carry             w_head;
    t_query             w_q;
    t_wr                w_wr;
    logic               w_acc;
    logic               w_src_ok;
    logic [SRC_IDX_W-1:0] w_src;
    logic [FRAME_W-1:0] w_fn;
    logic [FRAME_W-1:0] w_step;
    logic               w_free;
    logic               w_load;
    t_carry             c;

    // Decision results
    logic [SLOT_W-1:0]  d_newest;
    logic [SLOT_W-1:0]  d_retired;
    logic [SOURCES-1:0] d_sil;
    t_miss              d_miss;
    t_res               d_res0;
    t_res               d_res1;
    logic               d_two;
    logic               d_full;
    logic               d_compl;
    logic [SLOT_W-1:0]  d_n;
    logic [SOURCES-1:0] d_mask;
    logic [FRAME_W-1:0] d_frame;
    t_res               d_rep;
    t_res               d_push;
    t_sil_upd           d_upd;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_src_ok   = int'(i_s_tdata[2:0]) < SOURCES;
    assign w_src      = SRC_IDX_W'(i_s_tdata[2:0]);
    assign w_fn       = i_s_tdata[34:3];
    assign w_step     = (r_step == 2'd2) ? FRAME_W'(2) : FRAME_W'(1);
    assign w_free     = !r_out_v || i_m_tready;
    assign w_load     = w_free && (r_state == S_OUT0 || r_state == S_OUT1);

    // Search request, held steady while the token runs
    always_comb begin
        w_q.fn      = r_fn;
        w_q.srcbit  = SOURCES'(1) << r_src;
        w_q.sync    = r_sync;
        w_q.oldest  = ring_inc(r_retired);
        w_q.retired = r_retired;
        w_q.span    = ring_sub(r_newest, ring_inc(r_retired));
        w_q.live    = (r_newest != r_retired);
    end

    // Launch the token at the head of the chain
    always_comb begin
        w_head     = '0;
        w_head.tok = r_launch;
    end

    assign w_c[0] = w_head;

    genvar g;
    generate
        for (g = 0; g < RING_DEPTH; g++) begin : g_cell
            msfr_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (SLOT_W'(g)),
                .i_q     (w_q),
                .i_wr    (w_wr),
                .i_c     (w_c[g]),
                .o_c     (w_c[g+1])
            );
        end
    endgenerate

    assign c = w_c[RING_DEPTH];

    // Place the arrival from the search result and list its results
    always_comb begin
        d_newest  = r_newest;
        d_retired = r_retired;
        d_sil     = r_sil;
        d_miss    = r_miss;
        d_full    = 1'b0;
        d_compl   = 1'b0;
        d_n       = '0;
        d_mask    = '0;
        d_frame   = '0;
        d_two     = 1'b0;
        d_upd     = '0;
        w_wr      = '0;
        d_rep     = '0;
        d_rep.kind = KIND_REPORT;
        d_rep.gap  = r_gap;
        d_push     = '0;
        d_push.kind = KIND_PUSH;
        d_res0    = '0;
        d_res1    = '0;
        if (!c.found && r_sync && r_fn < c.ret_frame
                && (r_fn + FRAME_W'(LATE_WINDOW)) > c.ret_frame) begin
            // drop late arrival
            d_rep.outcome = OC_LATE;
            d_rep.sil     = MASK_FW'(d_sil);
            d_res0        = d_rep;
        end else if (c.found && (c.best_mask & w_q.srcbit) != '0) begin
            // drop duplicate
            d_rep.outcome = OC_DUP;
            d_rep.slot    = SLOT_FW'(c.best_idx);
            d_rep.sil     = MASK_FW'(d_sil);
            d_res0        = d_rep;
        end else begin
            if (!c.found) begin
                // open a new slot, pushing the oldest if the ring is full
                d_n      = ring_inc(r_newest);
                d_newest = d_n;
                d_full   = (ring_inc(d_n) == r_retired);
                if (d_full) begin
                    d_upd       = silent_update(d_sil, d_miss, c.old_mask);
                    d_sil       = d_upd.sil;
                    d_miss      = d_upd.miss;
                    d_retired   = w_q.oldest;
                    d_push.slot = SLOT_FW'(w_q.oldest);
                    d_push.pf   = c.old_frame;
                    d_push.pp   = MASK_FW'(c.old_mask);
                    d_push.sil  = MASK_FW'(d_sil);
                end
                d_mask        = (r_absent | d_sil) | w_q.srcbit;
                d_frame       = r_fn;
                d_rep.outcome = OC_OPEN;
            end else begin
                d_n           = c.best_idx;
                d_mask        = c.best_mask | w_q.srcbit;
                d_frame       = c.best_frame;
                d_rep.outcome = OC_JOIN;
            end
            d_miss[r_src] = '0;
            d_rep.slot    = SLOT_FW'(d_n);
            d_rep.sil     = MASK_FW'(d_sil);
            d_compl       = (d_n == ring_inc(d_retired)) && (d_mask == FULL_MASK);
            w_wr.en       = (r_state == S_DECIDE);
            w_wr.addr     = d_n;
            if (d_compl) begin
                // push the completed oldest frame and clear its slot
                d_upd       = silent_update(d_sil, d_miss, d_mask);
                d_sil       = d_upd.sil;
                d_miss      = d_upd.miss;
                d_retired   = d_n;
                d_push.slot = SLOT_FW'(d_n);
                d_push.pf   = d_frame;
                d_push.pp   = MASK_FW'(d_mask);
                d_push.sil  = MASK_FW'(d_sil);
            end else begin
                w_wr.frame = d_frame;
                w_wr.mask  = d_mask;
            end
            if (d_full) begin
                d_res0 = d_push;
                d_res1 = d_rep;
                d_two  = 1'b1;
            end else if (d_compl) begin
                d_res0 = d_rep;
                d_res1 = d_push;
                d_two  = 1'b1;
            end else begin
                d_res0 = d_rep;
            end
        end
        d_res0.last = !d_two;
        d_res1.last = 1'b1;
    end

    // Sequence control, ring pointers and tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_launch  <= 1'b0;
            r_absent  <= '0;
            r_step    <= 2'd1;
            r_newest  <= '0;
            r_retired <= '0;
            r_prev_v  <= '0;
            r_miss    <= '0;
            r_sil     <= '0;
            for (int i = 0; i < SOURCES; i++) r_prev[i] <= '0;
        end else begin
            r_launch <= (r_state == S_IDLE) && w_acc && w_src_ok;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ABSENT: r_absent <= SOURCES'(i_cfg_data);
                    CFG_STEP:   r_step   <= i_cfg_data[1:0];
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && w_src_ok) begin
                        r_src  <= w_src;
                        r_sync <= i_s_tuser;
                        r_fn   <= w_fn;
                        r_gap  <= r_prev_v[w_src] && ((w_fn - w_step) != r_prev[w_src]);
                        r_prev[w_src]   <= w_fn;
                        r_prev_v[w_src] <= 1'b1;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (c.tok) r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_newest  <= d_newest;
                    r_retired <= d_retired;
                    r_sil     <= d_sil;
                    r_miss    <= d_miss;
                    r_res0    <= d_res0;
                    r_res1    <= d_res1;
                    r_two     <= d_two;
                    r_state   <= S_OUT0;
                end
                S_OUT0: begin
                    if (w_free) begin
                        r_out   <= r_res0;
                        r_state <= r_two ? S_OUT1 : S_IDLE;
                    end
                end
                S_OUT1: begin
                    if (w_free) begin
                        r_out   <= r_res1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Raise valid when a result is loaded, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_load) begin
            r_out_v <= 1'b1;
        end else if (i_m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    // Drive the result channel from the output register
    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = {3'b000, r_out.sil, r_out.pp, r_out.pf, r_out.gap, r_out.slot,
                         r_out.outcome};

    // The ring never wraps onto its retired slot
    a_ring_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_inc(r_newest) != r_retired)
        else $error("ring overfilled");

    // A known source starts a search on the next cycle
    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_src_ok) |=> (r_launch && r_state == S_SCAN))
        else $error("search not launched");

    // The token leaves the chain only while a search is waiting for it
    a_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c.tok |-> (r_state == S_SCAN))
        else $error("stray search token");

endmodule
